// ----- design/ghull_pkg.sv -----
// Shared types and constants for the Graham scan convex hull block.
// No dependencies; imported by the top level, the product unit and the checker.
package ghull_pkg;

    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W_DEF    = 24;

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_OPEN = 2'd1,
        CLS_PI   = 2'd2
    } t_cls;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_xsign;

    function automatic t_cls f_class(input logic zero_z, input logic neg_r);
        t_cls c;
        if (!zero_z) c = CLS_OPEN;
        else if (neg_r) c = CLS_PI;
        else c = CLS_ZERO;
        return c;
    endfunction

endpackage

// ----- design/ghull_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ghull_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/ghull_xprod.sv -----
// Registered cross-product unit: sign of a*b - c*d.
// Depends on ghull_pkg for the result struct.
module ghull_xprod #(
    parameter int DW = 25
) (
    input  logic                 i_clk,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    input  logic signed [DW-1:0] i_c,
    input  logic signed [DW-1:0] i_d,
    output ghull_pkg::t_xsign    o_sign
);
    import ghull_pkg::*;

    logic signed [2*DW-1:0] r_p;
    logic signed [2*DW-1:0] r_q;
    logic signed [2*DW:0]   diff;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
        r_q <= i_c * i_d;
    end

    assign diff       = (2*DW+1)'(r_p) - (2*DW+1)'(r_q);
    assign o_sign.neg = diff[2*DW];
    assign o_sign.pos = !diff[2*DW] && (diff != '0);
endmodule

// ----- design/graham_scan_convex_hull_top.sv -----
// Graham scan convex hull: load points, find pivot, rank-sort by angle, scan, emit.
// Load accepts one point per cycle. After the last point (n stored) it finds the pivot,
// rank-sorts in the point-memory read loop, scans, and emits each hull point; with
// fewer than three points stored it skips pivot, sort and scan and emits them directly.
// Synchronous active-low reset returns to the load state with an empty store.
module graham_scan_convex_hull_top #(
    parameter int MAX_POINTS  = ghull_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = ghull_pkg::COORD_W_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // coord_r, coord_z, zero fill
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
    input  logic                                          s_axis_tlast,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // hull_r, hull_z, point_index, hull_size, zero fill
    output logic [((2*COORD_WIDTH+ghull_pkg::IDX_W+ghull_pkg::CNT_W+7)/8)*8-1:0]
                                                          m_axis_tdata,
    // overflow
    output logic                                          m_axis_tuser,
    output logic                                          m_axis_tlast
);
    import ghull_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int OUT_W = ((2*CW+IDX_W+CNT_W+7)/8)*8;
    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_POINTS);

    typedef enum logic [22:0] {
        S_LOAD     = 23'b1 << 0,
        S_PIV      = 23'b1 << 1,
        S_SINIT    = 23'b1 << 2,
        S_SNEXT    = 23'b1 << 3,
        S_SI       = 23'b1 << 4,
        S_SI2      = 23'b1 << 5,
        S_SRUN     = 23'b1 << 6,
        S_SC_A     = 23'b1 << 7,
        S_SC_B     = 23'b1 << 8,
        S_SC_C     = 23'b1 << 9,
        S_SC_CAND  = 23'b1 << 10,
        S_SC_CAND2 = 23'b1 << 11,
        S_SC_CAND3 = 23'b1 << 12,
        S_SC_TEST  = 23'b1 << 13,
        S_SC_DEC   = 23'b1 << 14,
        S_SC_POP1  = 23'b1 << 15,
        S_SC_POP2  = 23'b1 << 16,
        S_SC_POP3  = 23'b1 << 17,
        S_SC_PUSH  = 23'b1 << 18,
        S_E_RD     = 23'b1 << 19,
        S_E_ST     = 23'b1 << 20,
        S_E_RD2    = 23'b1 << 21,
        S_E_OUT    = 23'b1 << 22
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_j, n_j, r_i, n_i, r_rank, n_rank;
    logic [CNT_W-1:0] r_depth, n_depth, r_k, n_k;
    logic r_ovf, n_ovf, r_direct, n_direct, r_v1, n_v1, r_v2, n_v2;
    logic [IDX_W-1:0] r_pv, n_pv, r_j1, n_j1, r_j2, n_j2;
    logic [IDX_W-1:0] r_top_idx, n_top_idx, r_sec_idx, n_sec_idx;
    logic [IDX_W-1:0] r_cand_idx, n_cand_idx, r_eidx, n_eidx;
    logic signed [CW-1:0] r_pvr, n_pvr, r_pvz, n_pvz;
    logic signed [CW-1:0] r_top_r, n_top_r, r_top_z, n_top_z;
    logic signed [CW-1:0] r_sec_r, n_sec_r, r_sec_z, n_sec_z;
    logic signed [CW-1:0] r_cand_r, n_cand_r, r_cand_z, n_cand_z;
    logic signed [DW-1:0] r_br, n_br, r_bz, n_bz;
    t_cls r_cb, n_cb, r_ca2, n_ca2;
    logic r_o_valid, n_o_valid, r_o_last, n_o_last, r_o_ovf, n_o_ovf;
    logic signed [CW-1:0] r_o_r, n_o_r, r_o_z, n_o_z;
    logic [IDX_W-1:0] r_o_idx, n_o_idx;
    logic [CNT_W-1:0] r_o_size, n_o_size;

    logic              pt_we;
    logic [IDX_W-1:0]  pt_waddr, pt_raddr;
    logic [2*CW-1:0]   pt_wdata, pt_rdata;
    logic              so_we, st_we;
    logic [IDX_W-1:0]  so_waddr, so_raddr, so_wdata, so_rdata;
    logic [IDX_W-1:0]  st_waddr, st_raddr, st_wdata, st_rdata;
    logic signed [CW-1:0] d_r, d_z;
    logic signed [DW-1:0] ar, az, xa, xb, xc, xd;
    t_cls              ca;
    t_xsign            xs;
    logic              in_acc, bef, has_room;
    logic [CNT_W-1:0]  cnt_after, emit_size;

    ghull_ram #(.W(2*CW), .DEPTH(MAX_POINTS)) u_pts (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_waddr[AW-1:0]), .i_wdata(pt_wdata),
        .i_raddr(pt_raddr[AW-1:0]), .o_rdata(pt_rdata)
    );
    ghull_ram #(.W(IDX_W), .DEPTH(MAX_POINTS)) u_sorted (
        .i_clk(i_clk), .i_we(so_we), .i_waddr(so_waddr[AW-1:0]), .i_wdata(so_wdata),
        .i_raddr(so_raddr[AW-1:0]), .o_rdata(so_rdata)
    );
    ghull_ram #(.W(IDX_W), .DEPTH(MAX_POINTS)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr[AW-1:0]), .i_wdata(st_wdata),
        .i_raddr(st_raddr[AW-1:0]), .o_rdata(st_rdata)
    );
    ghull_xprod #(.DW(DW)) u_xprod (
        .i_clk(i_clk), .i_a(xa), .i_b(xb), .i_c(xc), .i_d(xd), .o_sign(xs)
    );

    assign d_r       = pt_rdata[CW-1:0];
    assign d_z       = pt_rdata[2*CW-1:CW];
    assign ar        = DW'(d_r) - DW'(r_pvr);
    assign az        = DW'(d_z) - DW'(r_pvz);
    assign ca        = f_class(az == '0, ar[DW-1]);
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign has_room  = r_cnt < MAXC;
    assign cnt_after = has_room ? r_cnt + CNT_W'(1) : r_cnt;
    assign emit_size = r_direct ? r_cnt : r_depth;

    always_comb begin
        if (r_state == S_SRUN) begin
            xa = ar;
            xb = r_bz;
            xc = r_br;
            xd = az;
        end else begin
            xa = DW'(r_top_r) - DW'(r_sec_r);
            xb = DW'(r_cand_z) - DW'(r_sec_z);
            xc = DW'(r_cand_r) - DW'(r_sec_r);
            xd = DW'(r_top_z) - DW'(r_sec_z);
        end
    end

    always_comb begin
        if (r_ca2 != r_cb) bef = r_ca2 < r_cb;
        else if (r_ca2 == CLS_OPEN && (xs.pos || xs.neg)) bef = xs.pos;
        else bef = r_j2 < r_i[IDX_W-1:0];
    end

    always_comb begin
        n_state = r_state;   n_cnt = r_cnt;     n_j = r_j;         n_i = r_i;
        n_rank = r_rank;     n_depth = r_depth; n_k = r_k;         n_ovf = r_ovf;
        n_direct = r_direct; n_v1 = 1'b0;       n_v2 = 1'b0;       n_pv = r_pv;
        n_j1 = r_j[IDX_W-1:0]; n_j2 = r_j1;     n_top_idx = r_top_idx;
        n_sec_idx = r_sec_idx; n_cand_idx = r_cand_idx; n_eidx = r_eidx;
        n_pvr = r_pvr;       n_pvz = r_pvz;     n_top_r = r_top_r; n_top_z = r_top_z;
        n_sec_r = r_sec_r;   n_sec_z = r_sec_z; n_cand_r = r_cand_r; n_cand_z = r_cand_z;
        n_br = r_br;         n_bz = r_bz;       n_cb = r_cb;       n_ca2 = ca;
        n_o_valid = r_o_valid; n_o_last = r_o_last; n_o_ovf = r_o_ovf;
        n_o_r = r_o_r;       n_o_z = r_o_z;     n_o_idx = r_o_idx; n_o_size = r_o_size;
        pt_we = 1'b0;        pt_waddr = r_cnt[IDX_W-1:0];
        pt_wdata = s_axis_tdata[2*CW-1:0];
        pt_raddr = r_j[IDX_W-1:0];
        so_we = 1'b0;        so_waddr = r_rank[IDX_W-1:0]; so_wdata = r_i[IDX_W-1:0];
        so_raddr = r_i[IDX_W-1:0];
        st_we = 1'b0;        st_waddr = r_depth[IDX_W-1:0]; st_wdata = r_cand_idx;
        st_raddr = r_k[IDX_W-1:0];
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    pt_we = has_room;
                    n_cnt = cnt_after;
                    if (!has_room) n_ovf = 1'b1;
                    if (s_axis_tlast) begin
                        n_j = '0;
                        n_k = '0;
                        if (cnt_after < CNT_W'(3)) begin
                            n_direct = 1'b1;
                            n_state  = S_E_RD;
                        end else begin
                            n_direct = 1'b0;
                            n_state  = S_PIV;
                        end
                    end
                end
            end
            S_PIV: begin
                if (r_j < r_cnt) begin
                    n_v1 = 1'b1;
                    n_j  = r_j + CNT_W'(1);
                end
                if (r_v1 && (r_j1 == '0 || d_z < r_pvz)) begin
                    n_pv  = r_j1;
                    n_pvr = d_r;
                    n_pvz = d_z;
                end
                if (r_j == r_cnt && !r_v1) n_state = S_SINIT;
            end
            S_SINIT: begin
                so_we    = 1'b1;
                so_waddr = '0;
                so_wdata = r_pv;
                n_i      = '0;
                n_state  = S_SNEXT;
            end
            S_SNEXT: begin
                if (r_i == r_cnt) n_state = S_SC_A;
                else if (r_i[IDX_W-1:0] == r_pv) n_i = r_i + CNT_W'(1);
                else n_state = S_SI;
            end
            S_SI: begin
                pt_raddr = r_i[IDX_W-1:0];
                n_state  = S_SI2;
            end
            S_SI2: begin
                n_br    = ar;
                n_bz    = az;
                n_cb    = ca;
                n_j     = '0;
                n_rank  = CNT_W'(1);
                n_state = S_SRUN;
            end
            S_SRUN: begin
                if (r_j < r_cnt) begin
                    n_v1 = 1'b1;
                    n_j  = r_j + CNT_W'(1);
                end
                n_v2 = r_v1 && (r_j1 != r_pv);
                if (r_v2 && bef) n_rank = r_rank + CNT_W'(1);
                if (r_j == r_cnt && !r_v1 && !r_v2) begin
                    so_we   = 1'b1;
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SNEXT;
                end
            end
            S_SC_A: begin
                so_raddr = IDX_W'(1);
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = r_pv;
                n_state  = S_SC_B;
            end
            S_SC_B: begin
                n_top_idx = so_rdata;
                pt_raddr  = so_rdata;
                n_state   = S_SC_C;
            end
            S_SC_C: begin
                n_top_r   = d_r;
                n_top_z   = d_z;
                st_we     = 1'b1;
                st_waddr  = IDX_W'(1);
                st_wdata  = r_top_idx;
                n_sec_idx = r_pv;
                n_sec_r   = r_pvr;
                n_sec_z   = r_pvz;
                n_depth   = CNT_W'(2);
                n_i       = CNT_W'(2);
                n_state   = S_SC_CAND;
            end
            S_SC_CAND: begin
                so_raddr = r_i[IDX_W-1:0];
                n_state  = S_SC_CAND2;
            end
            S_SC_CAND2: begin
                n_cand_idx = so_rdata;
                pt_raddr   = so_rdata;
                n_state    = S_SC_CAND3;
            end
            S_SC_CAND3: begin
                n_cand_r = d_r;
                n_cand_z = d_z;
                n_state  = S_SC_TEST;
            end
            S_SC_TEST: begin
                n_state = (r_depth >= CNT_W'(2)) ? S_SC_DEC : S_SC_PUSH;
            end
            S_SC_DEC: begin
                if (xs.neg) begin
                    n_depth   = r_depth - CNT_W'(1);
                    n_top_idx = r_sec_idx;
                    n_top_r   = r_sec_r;
                    n_top_z   = r_sec_z;
                    n_state   = (r_depth >= CNT_W'(3)) ? S_SC_POP1 : S_SC_PUSH;
                end else begin
                    n_state = S_SC_PUSH;
                end
            end
            S_SC_POP1: begin
                st_raddr = IDX_W'(r_depth - CNT_W'(2));
                n_state  = S_SC_POP2;
            end
            S_SC_POP2: begin
                n_sec_idx = st_rdata;
                pt_raddr  = st_rdata;
                n_state   = S_SC_POP3;
            end
            S_SC_POP3: begin
                n_sec_r = d_r;
                n_sec_z = d_z;
                n_state = S_SC_TEST;
            end
            S_SC_PUSH: begin
                st_we     = 1'b1;
                n_sec_idx = r_top_idx;
                n_sec_r   = r_top_r;
                n_sec_z   = r_top_z;
                n_top_idx = r_cand_idx;
                n_top_r   = r_cand_r;
                n_top_z   = r_cand_z;
                n_depth   = r_depth + CNT_W'(1);
                n_i       = r_i + CNT_W'(1);
                n_k       = '0;
                n_state   = (r_i + CNT_W'(1) == r_cnt) ? S_E_RD : S_SC_CAND;
            end
            S_E_RD: begin
                pt_raddr = r_k[IDX_W-1:0];
                n_eidx   = r_k[IDX_W-1:0];
                n_state  = r_direct ? S_E_RD2 : S_E_ST;
            end
            S_E_ST: begin
                n_eidx   = st_rdata;
                pt_raddr = st_rdata;
                n_state  = S_E_RD2;
            end
            S_E_RD2: begin
                n_o_valid = 1'b1;
                n_o_r     = d_r;
                n_o_z     = d_z;
                n_o_idx   = r_eidx;
                n_o_size  = emit_size;
                n_o_last  = (r_k + CNT_W'(1)) == emit_size;
                n_o_ovf   = r_ovf;
                n_state   = S_E_OUT;
            end
            S_E_OUT: begin
                if (m_axis_tready) begin
                    n_o_valid = 1'b0;
                    n_k       = r_k + CNT_W'(1);
                    if (r_o_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_E_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ovf     <= n_ovf;
            r_v1      <= n_v1;
            r_v2      <= n_v2;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j <= n_j;         r_i <= n_i;         r_rank <= n_rank;   r_depth <= n_depth;
        r_k <= n_k;         r_direct <= n_direct; r_pv <= n_pv;     r_j1 <= n_j1;
        r_j2 <= n_j2;       r_top_idx <= n_top_idx; r_sec_idx <= n_sec_idx;
        r_cand_idx <= n_cand_idx; r_eidx <= n_eidx; r_pvr <= n_pvr; r_pvz <= n_pvz;
        r_top_r <= n_top_r; r_top_z <= n_top_z; r_sec_r <= n_sec_r; r_sec_z <= n_sec_z;
        r_cand_r <= n_cand_r; r_cand_z <= n_cand_z; r_br <= n_br;   r_bz <= n_bz;
        r_cb <= n_cb;       r_ca2 <= n_ca2;     r_o_last <= n_o_last; r_o_ovf <= n_o_ovf;
        r_o_r <= n_o_r;     r_o_z <= n_o_z;     r_o_idx <= n_o_idx; r_o_size <= n_o_size;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_W'({r_o_size, r_o_idx, r_o_z, r_o_r});
    assign m_axis_tuser  = r_o_ovf;
    assign m_axis_tlast  = r_o_last;
endmodule

// ----- design/ghull_checker.sv -----
// Port-level checker for the convex hull block, bound to the top level.
// Depends on ghull_pkg for field widths.
module ghull_checker #(
    parameter int MAX_POINTS  = ghull_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = ghull_pkg::COORD_W_DEF
) (
    input logic                                          i_clk,
    input logic                                          i_rst_n,
    input logic                                          s_axis_tvalid,
    input logic                                          s_axis_tready,
    // coord_r, coord_z, zero fill
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
    input logic                                          s_axis_tlast,
    input logic                                          m_axis_tvalid,
    input logic                                          m_axis_tready,
    // hull_r, hull_z, point_index, hull_size, zero fill
    input logic [((2*COORD_WIDTH+ghull_pkg::IDX_W+ghull_pkg::CNT_W+7)/8)*8-1:0]
                                                         m_axis_tdata,
    // overflow
    input logic                                          m_axis_tuser,
    input logic                                          m_axis_tlast
);
    import ghull_pkg::*;

    localparam int SZ_LO = 2*COORD_WIDTH + IDX_W;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while output item pending");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not back to load after final hull item");

    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("load reopened before final hull item");

    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[SZ_LO +: CNT_W] != '0 &&
                          m_axis_tdata[SZ_LO +: CNT_W] <= CNT_W'(MAX_POINTS))
        else $error("hull size out of range");
endmodule

bind graham_scan_convex_hull_top ghull_checker #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH)
) u_ghull_checker (.*);
